// ===== rtl/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared constants and types for the first-fit bin allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int unsigned MaxBinsDef = 16;

  localparam int unsigned SizeW  = 6;
  localparam int unsigned LoadW  = 6;
  localparam int unsigned IndexW = 4;
  localparam int unsigned RegW   = 5;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  localparam logic [LoadW-1:0] CapSmall  = 6'd10;
  localparam logic [LoadW-1:0] CapMedium = 6'd32;
  localparam logic [LoadW-1:0] CapLarge  = 6'd40;

  typedef enum logic [1:0] {
    RegBinCount  = 2'd0,
    RegSmallEnd  = 2'd1,
    RegMediumEnd = 2'd2,
    RegNone      = 2'd3
  } reg_idx_e;

  typedef enum logic {
    StIdle,
    StScan
  } state_e;

endpackage

// ===== rtl/ffba_ram.sv =====
// ----------------------------------------------------------------------------
// ffba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffba_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/first_fit_bin_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_bin_allocator
// First-fit placement of sized requests over a row of bins with three
// capacity classes, loads held in a RAM and scanned one bin per cycle.
// With a bin count of zero the miss is registered with no scan; else bins
//   are scanned from bin 0 until a fit or min(bin count, MAX_BINS) bins.
// A new request is not taken during a scan; the next start is taken at the
//   edge that ends the result cycle. The scan pace is set by the single RAM
//   read port and the shared fit compare visiting one bin per cycle.
// Reset: async active low; clears valid bits, config and control registers.
// Results are strobed on done_o for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module first_fit_bin_allocator #(
  parameter int unsigned MAX_BINS = ffba_pkg::MaxBinsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ffba_pkg::AddrW-1:0]   paddr,
  input  logic [ffba_pkg::DataW-1:0]   pwdata,
  output logic [ffba_pkg::DataW-1:0]   prdata,
  output logic                         pready,
  input  logic                         start_i,
  input  logic [ffba_pkg::SizeW-1:0]   request_size_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic                         placed_o,
  output logic [ffba_pkg::IndexW-1:0]  bin_index_o,
  output logic [ffba_pkg::LoadW-1:0]   bin_load_o
);
  import ffba_pkg::*;

  localparam int unsigned IdxW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int unsigned CntW = $clog2(MAX_BINS + 1);
  localparam int unsigned CmpW = (CntW > RegW) ? CntW : RegW;

  // configuration
  logic [RegW-1:0] bin_count_q, small_end_q, medium_end_q;
  reg_idx_e        reg_sel;
  logic            cfg_wr;

  assign reg_sel = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_count_q  <= '0;
      small_end_q  <= '0;
      medium_end_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        RegBinCount:  bin_count_q  <= pwdata[RegW-1:0];
        RegSmallEnd:  small_end_q  <= pwdata[RegW-1:0];
        RegMediumEnd: medium_end_q <= pwdata[RegW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      RegBinCount:  prdata[RegW-1:0] = bin_count_q;
      RegSmallEnd:  prdata[RegW-1:0] = small_end_q;
      RegMediumEnd: prdata[RegW-1:0] = medium_end_q;
      default:      prdata = '0;
    endcase
  end

  // sequencer
  state_e          state_q, state_d;
  logic [IdxW-1:0] idx_q;
  logic [CntW-1:0] lim_q;
  logic [SizeW-1:0] size_q;
  logic [MAX_BINS-1:0] valid_q;

  logic            accept;
  logic [CmpW-1:0] cnt_ext, lim_new;
  logic [CmpW-1:0] idx_ext;
  logic [CntW-1:0] idx_nxt_cnt;
  logic            last_bin;
  logic [LoadW-1:0] rd_data, load_cur, cap_cur;
  logic [LoadW:0]  sum;
  logic            fit;
  logic [IdxW-1:0] rd_addr;
  logic            wr_en;
  logic [IdxW+IndexW-1:0] idx_wide;

  assign accept  = start_i && (state_q == StIdle);
  assign cnt_ext = CmpW'(bin_count_q);
  assign lim_new = (cnt_ext > CmpW'(MAX_BINS)) ? CmpW'(MAX_BINS) : cnt_ext;

  assign idx_ext     = CmpW'(idx_q);
  assign idx_nxt_cnt = CntW'(idx_q) + CntW'(1);
  assign last_bin    = (idx_nxt_cnt == lim_q);

  assign load_cur = valid_q[idx_q] ? rd_data : '0;
  assign cap_cur  = (idx_ext < CmpW'(small_end_q))  ? CapSmall  :
                    (idx_ext < CmpW'(medium_end_q)) ? CapMedium : CapLarge;
  assign sum      = {1'b0, load_cur} + {1'b0, size_q};
  assign fit      = (sum <= {1'b0, cap_cur});
  assign wr_en    = (state_q == StScan) && fit;
  assign idx_wide = {{IndexW{1'b0}}, idx_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (start_i && (lim_new != '0)) state_d = StScan;
      StScan: if (fit || last_bin) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    busy_o  = 1'b0;
    rd_addr = '0;
    unique case (state_q)
      StIdle: begin
        busy_o  = 1'b0;
        rd_addr = '0;
      end
      StScan: begin
        busy_o  = 1'b1;
        rd_addr = IdxW'(idx_nxt_cnt);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= '0;
      lim_q       <= '0;
      valid_q     <= '0;
      done_o      <= 1'b0;
      placed_o    <= 1'b0;
      bin_index_o <= '0;
      bin_load_o  <= '0;
    end else begin
      state_q <= state_d;
      done_o  <= 1'b0;
      if (accept) begin
        idx_q <= '0;
        lim_q <= CntW'(lim_new);
        if (lim_new == '0) begin
          done_o      <= 1'b1;
          placed_o    <= 1'b0;
          bin_index_o <= '0;
          bin_load_o  <= '0;
        end
      end else if (state_q == StScan) begin
        idx_q <= IdxW'(idx_nxt_cnt);
        if (fit) begin
          valid_q[idx_q] <= 1'b1;
          done_o         <= 1'b1;
          placed_o       <= 1'b1;
          bin_index_o    <= idx_wide[IndexW-1:0];
          bin_load_o     <= sum[LoadW-1:0];
        end else if (last_bin) begin
          done_o      <= 1'b1;
          placed_o    <= 1'b0;
          bin_index_o <= '0;
          bin_load_o  <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      size_q <= request_size_i;
    end
  end

  ffba_ram #(
    .Width(LoadW),
    .Depth(MAX_BINS)
  ) u_load_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(idx_q),
    .wdata_i(sum[LoadW-1:0]),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

endmodule

// ===== rtl/ffba_checker.sv =====
// ----------------------------------------------------------------------------
// ffba_checker
// Port-level checks for the first-fit bin allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffba_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         pready,
  input logic                         start_i,
  input logic                         busy_o,
  input logic                         done_o,
  input logic                         placed_o,
  input logic [ffba_pkg::IndexW-1:0]  bin_index_o,
  input logic [ffba_pkg::LoadW-1:0]   bin_load_o
);
  import ffba_pkg::*;

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !placed_o |-> (bin_index_o == '0) && (bin_load_o == '0))
    else $error("miss result carries nonzero fields");

  a_load_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && placed_o |-> bin_load_o <= CapLarge)
    else $error("placed load above largest capacity");

  a_start_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o || done_o)
    else $error("accepted request neither scanned nor answered");

  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("scan ended without a result");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

endmodule

bind first_fit_bin_allocator ffba_checker u_ffba_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .pready     (pready),
  .start_i    (start_i),
  .busy_o     (busy_o),
  .done_o     (done_o),
  .placed_o   (placed_o),
  .bin_index_o(bin_index_o),
  .bin_load_o (bin_load_o)
);
